@@ rtl/tcb_pkg.sv @@
`default_nettype none

package tcb_pkg;

	localparam int BUFFER_DEPTH = 256;
	localparam int SAMPLE_BITS  = 12;

	localparam int CMD_W   = 3;
	localparam int VALUE_W = 12;
	localparam int INDEX_W = 8;
	localparam int DATA_W  = 12;
	localparam int MODE_W  = 2;

	localparam int ADDR_W     = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int POST_LIMIT = BUFFER_DEPTH / 2;
	localparam int CNT_W      = $clog2(POST_LIMIT + 1);

	typedef enum logic [CMD_W-1:0] {
		CMD_SAMPLE  = 3'd0,
		CMD_ARM     = 3'd1,
		CMD_TRIGGER = 3'd2,
		CMD_READ    = 3'd3,
		CMD_CLEAR   = 3'd4
	} cmd_t;

	typedef enum logic [3:0] {
		MODE_IDLE = 4'b0001,
		MODE_PRE  = 4'b0010,
		MODE_POST = 4'b0100,
		MODE_DONE = 4'b1000
	} mode_t;

	localparam logic [MODE_W-1:0] MODE_CODE_IDLE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CODE_PRE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CODE_POST = 2'd2;
	localparam logic [MODE_W-1:0] MODE_CODE_DONE = 2'd3;

	typedef struct packed {
		logic                   we;
		logic [ADDR_W-1:0]      waddr;
		logic [SAMPLE_BITS-1:0] wdata;
		logic                   re;
		logic [ADDR_W-1:0]      raddr;
	} mem_req_t;

	typedef struct packed {
		logic              hit;
		logic [MODE_W-1:0] mode;
	} step_info_t;

	function automatic logic [MODE_W-1:0] mode_code(mode_t m);
		logic [MODE_W-1:0] c;
		unique case (m)
			MODE_IDLE: c = MODE_CODE_IDLE;
			MODE_PRE:  c = MODE_CODE_PRE;
			MODE_POST: c = MODE_CODE_POST;
			MODE_DONE: c = MODE_CODE_DONE;
			default:   c = MODE_CODE_IDLE;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

@@ rtl/tcb_if.sv @@
`default_nettype none

interface tcb_req_if;
	import tcb_pkg::*;

	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [VALUE_W-1:0] sample_value;
	logic [INDEX_W-1:0] read_index;

	modport source (output valid, command, sample_value, read_index, input ready);
	modport sink   (input valid, command, sample_value, read_index, output ready);
endinterface

interface tcb_rsp_if;
	import tcb_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] read_data;
	logic              read_valid;
	logic              capture_done;
	logic [MODE_W-1:0] mode_now;

	modport source (output valid, read_data, read_valid, capture_done, mode_now, input ready);
	modport sink   (input valid, read_data, read_valid, capture_done, mode_now, output ready);
endinterface

`default_nettype wire

@@ rtl/tcb_ram.sv @@
`default_nettype none

module tcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/tcb_ctrl.sv @@
`default_nettype none

module tcb_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        acc,
	input  wire logic [tcb_pkg::CMD_W-1:0]   command,
	input  wire logic [tcb_pkg::VALUE_W-1:0] sample_value,
	input  wire logic [tcb_pkg::INDEX_W-1:0] read_index,
	output logic                             busy,
	output tcb_pkg::mem_req_t                mem,
	output tcb_pkg::step_info_t              info
);
	import tcb_pkg::*;

	typedef logic [ADDR_W-1:0] idx_tab_t [2**INDEX_W];

	function automatic idx_tab_t build_idx_mod();
		idx_tab_t t;
		for (int i = 0; i < 2**INDEX_W; i++) begin
			t[i] = ADDR_W'(i % BUFFER_DEPTH);
		end
		return t;
	endfunction

	localparam idx_tab_t IDX_MOD = build_idx_mod();
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BUFFER_DEPTH - 1);
	localparam logic [ADDR_W:0]   DEPTH_EXT = (ADDR_W + 1)'(BUFFER_DEPTH);

	mode_t             mode_q, mode_d;
	logic [ADDR_W-1:0] wp_q, wp_d, wp_inc;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic              clr_q, clr_start;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [ADDR_W:0]   rsum;

	assign busy   = clr_q;
	assign wp_inc = (wp_q == LAST_ADDR) ? '0 : wp_q + 1'b1;
	assign rsum   = {1'b0, wp_q} + {1'b0, IDX_MOD[read_index]};

	always_comb begin
		mode_d    = mode_q;
		wp_d      = wp_q;
		cnt_d     = cnt_q;
		clr_start = 1'b0;
		info.hit  = 1'b0;

		mem.we    = 1'b0;
		mem.waddr = wp_q;
		mem.wdata = SAMPLE_BITS'(sample_value);
		mem.re    = 1'b0;
		mem.raddr = (rsum >= DEPTH_EXT) ? ADDR_W'(rsum - DEPTH_EXT) : ADDR_W'(rsum);

		if (clr_q) begin
			mem.we    = 1'b1;
			mem.waddr = clr_addr_q;
			mem.wdata = '0;
		end

		if (acc) begin
			unique case (command)
				CMD_SAMPLE: begin
					if (mode_q == MODE_PRE || mode_q == MODE_POST) begin
						mem.we = 1'b1;
						wp_d   = wp_inc;
						if (mode_q == MODE_POST) begin
							if (cnt_q < CNT_W'(POST_LIMIT)) begin
								cnt_d = cnt_q + 1'b1;
							end else begin
								cnt_d  = '0;
								mode_d = MODE_DONE;
							end
						end
					end
				end
				CMD_ARM: begin
					wp_d   = '0;
					cnt_d  = '0;
					mode_d = MODE_PRE;
				end
				CMD_TRIGGER: begin
					mode_d = MODE_POST;
				end
				CMD_READ: begin
					if (mode_q == MODE_DONE) begin
						mem.re   = 1'b1;
						info.hit = 1'b1;
					end
				end
				CMD_CLEAR: begin
					wp_d      = '0;
					cnt_d     = '0;
					clr_start = 1'b1;
				end
				default: begin
				end
			endcase
		end

		info.mode = mode_code(mode_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			wp_q       <= '0;
			cnt_q      <= '0;
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			mode_q <= mode_d;
			wp_q   <= wp_d;
			cnt_q  <= cnt_d;
			if (clr_start) begin
				clr_q      <= 1'b1;
				clr_addr_q <= '0;
			end else if (clr_q) begin
				if (clr_addr_q == LAST_ADDR) begin
					clr_q <= 1'b0;
				end
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/triggered_capture_buffer.sv @@
// A transaction's result is registered in stage 1, then in the output register.
// Throughput: one transaction per cycle when rsp.ready does not stall the output,
// limited by the single sample RAM port pair. A clear transaction stalls the
// request side while the RAM is zeroed. Reset is asynchronous, active low;
// after release the RAM is zeroed before the first transaction is accepted.
`default_nettype none

module triggered_capture_buffer (
	input  wire logic clk,
	input  wire logic arst_n,
	tcb_req_if.sink   req,
	tcb_rsp_if.source rsp
);
	import tcb_pkg::*;

	logic                   busy, acc, s1_move;
	mem_req_t               mem;
	step_info_t             info;
	logic [SAMPLE_BITS-1:0] rdata;

	logic              vld_s1, hit_s1;
	logic [MODE_W-1:0] mode_s1;

	logic              out_vld_q, rv_q, done_q;
	logic [DATA_W-1:0] data_q;
	logic [MODE_W-1:0] mode_q;

	assign s1_move   = vld_s1 && (!out_vld_q || rsp.ready);
	assign req.ready = !busy && (!vld_s1 || s1_move);
	assign acc       = req.valid && req.ready;

	tcb_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.acc          (acc),
		.command      (req.command),
		.sample_value (req.sample_value),
		.read_index   (req.read_index),
		.busy         (busy),
		.mem          (mem),
		.info         (info)
	);

	tcb_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (BUFFER_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem.we),
		.waddr (mem.waddr),
		.wdata (mem.wdata),
		.re    (mem.re),
		.raddr (mem.raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (acc) begin
				vld_s1 <= 1'b1;
			end else if (s1_move) begin
				vld_s1 <= 1'b0;
			end
			if (s1_move) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			hit_s1  <= info.hit;
			mode_s1 <= info.mode;
		end
		if (s1_move) begin
			data_q <= hit_s1 ? DATA_W'(rdata) : '0;
			rv_q   <= hit_s1;
			done_q <= (mode_s1 == MODE_CODE_DONE);
			mode_q <= mode_s1;
		end
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.read_data    = data_q;
	assign rsp.read_valid   = rv_q;
	assign rsp.capture_done = done_q;
	assign rsp.mode_now     = mode_q;

endmodule

`default_nettype wire

@@ rtl/tcb_checker.sv @@
`default_nettype none

module tcb_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       rsp_valid,
	input wire logic                       rsp_ready,
	input wire logic [tcb_pkg::DATA_W-1:0] rsp_read_data,
	input wire logic                       rsp_read_valid,
	input wire logic                       rsp_capture_done,
	input wire logic [tcb_pkg::MODE_W-1:0] rsp_mode_now
);
	import tcb_pkg::*;

	a_hit_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_read_valid |-> rsp_capture_done && rsp_mode_now == MODE_CODE_DONE)
		else $error("read served outside a complete capture");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_read_valid |-> rsp_read_data == '0)
		else $error("read data nonzero without read_valid");

	a_done_matches_mode: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_capture_done == (rsp_mode_now == MODE_CODE_DONE))
		else $error("capture_done disagrees with mode_now");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data)
			&& $stable(rsp_mode_now))
		else $error("stalled response transaction changed");

endmodule

bind triggered_capture_buffer tcb_checker u_tcb_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_read_data    (rsp.read_data),
	.rsp_read_valid   (rsp.read_valid),
	.rsp_capture_done (rsp.capture_done),
	.rsp_mode_now     (rsp.mode_now)
);

`default_nettype wire
